// ===== src/egsd_pkg.sv =====
// shared constants, types and the signed mapping for the exp-golomb stream decoder
package egsd_pkg;

    // longest prefix of zero bits accepted before the code is thrown away
    localparam int unsigned MAX_PREFIX_ZEROS = 32;

    // width of the prefix and suffix counters, enough to hold MAX_PREFIX_ZEROS
    localparam int unsigned CNT_W = $clog2(MAX_PREFIX_ZEROS + 1);

    // width of a decoded value
    localparam int unsigned VAL_W = 32;

    typedef logic [1:0] status_t;

    // result status codes
    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_TRUNC = 2'd1;
    localparam status_t STATUS_OVF   = 2'd2;

    // se(v) mapping: odd k gives (k+1)/2 saturated, even k gives -(k/2)
    function automatic logic [VAL_W-1:0] se_map(input logic [VAL_W-1:0] u);
        logic [VAL_W-1:0] half;
        logic [VAL_W-1:0] res;
        half = {1'b0, u[VAL_W-1:1]};
        if (u[0])
        begin
            if (&u)
            begin
                res = {1'b0, {(VAL_W-1){1'b1}}};
            end
            else
            begin
                res = half + {{(VAL_W-1){1'b0}}, 1'b1};
            end
        end
        else
        begin
            res = {VAL_W{1'b0}} - half;
        end
        return res;
    endfunction

endpackage

// ===== src/exp_golomb_stream_decoder.sv =====
// top level of the order-0 exp-golomb stream decoder: bit sequencer and result registers
//
// Decodes back-to-back order-0 Exp-Golomb codes from a byte stream, most significant
// bit first. Prefix count, suffix progress and the suffix accumulator carry over from
// one byte to the next. Each finished code gives ue(v) and se(v); more than 32 leading
// zeros gives an overflow status and decoding restarts at the next bit, and a code still
// open after a byte marked last_byte gives a truncated status. last_of_run marks the final
// result caused by a byte. One shared bit-step unit walks the byte one bit per cycle while no
// finished result is held up by out_stall; a byte takes 8 bit steps, one end-of-stream check
// and a flush step that hands over the final result, if one is pending. in_stall stays high
// from acceptance until the flush step is done, so no new byte is taken before then.
module exp_golomb_stream_decoder
    import egsd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // input requests
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    // result requests
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [VAL_W-1:0]        unsigned_value,
    output logic signed [VAL_W-1:0] signed_value,
    output status_t                 status,
    output logic                    last_of_run
);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BITS  = 2'd1;
    localparam logic [1:0] S_END   = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [2:0]       bit_cnt_reg, bit_cnt_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;

    // code state carried across bytes
    logic [CNT_W-1:0] zero_count_reg, zero_count_next;
    logic             in_suffix_reg, in_suffix_next;
    logic [CNT_W-1:0] suffix_left_reg, suffix_left_next;
    logic [VAL_W-1:0] suffix_acc_reg, suffix_acc_next;

    // one result held back until it is known whether another follows
    logic             pend_valid_reg, pend_valid_next;
    logic [VAL_W-1:0] pend_uval_reg, pend_uval_next;
    status_t          pend_status_reg, pend_status_next;

    // output register
    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] out_uval_reg, out_uval_next;
    logic [VAL_W-1:0] out_sval_reg, out_sval_next;
    status_t          out_status_reg, out_status_next;
    logic             out_last_reg, out_last_next;

    // bit-step unit outputs
    logic             cur_bit;
    logic             res_fire;
    logic [VAL_W-1:0] res_uval;
    status_t          res_status;
    logic [CNT_W-1:0] step_zc;
    logic             step_in_suffix;
    logic [CNT_W-1:0] step_left;
    logic [VAL_W-1:0] step_acc;
    logic [VAL_W:0]   code_base;
    logic [VAL_W:0]   code_sum;
    logic             out_free;
    logic             can_go;

    assign cur_bit  = byte_reg[7];
    assign out_free = !out_valid_reg || !out_stall;

    // value of a finished code: 2^n - 1 plus suffix with the current bit, saturated to 32 bits
    assign code_base = ~({(VAL_W+1){1'b1}} << zero_count_reg);
    assign code_sum  = code_base + {1'b0, suffix_acc_reg[VAL_W-2:0], cur_bit};

    // bit-step unit: one stream bit, or the end-of-stream check
    always_comb
    begin
        res_fire       = 1'b0;
        res_uval       = '0;
        res_status     = STATUS_OK;
        step_zc        = zero_count_reg;
        step_in_suffix = in_suffix_reg;
        step_left      = suffix_left_reg;
        step_acc       = {suffix_acc_reg[VAL_W-2:0], cur_bit};
        if (state_reg == S_END)
        begin
            step_acc = suffix_acc_reg;
            if (last_reg)
            begin
                res_fire       = in_suffix_reg || (zero_count_reg != '0);
                res_status     = STATUS_TRUNC;
                step_zc        = '0;
                step_in_suffix = 1'b0;
                step_left      = '0;
                step_acc       = '0;
            end
        end
        else if (!in_suffix_reg)
        begin
            step_acc = suffix_acc_reg;
            if (!cur_bit)
            begin
                if (zero_count_reg == CNT_W'(MAX_PREFIX_ZEROS))
                begin
                    res_fire   = 1'b1;
                    res_status = STATUS_OVF;
                    step_zc    = '0;
                    step_left  = '0;
                    step_acc   = '0;
                end
                else
                begin
                    step_zc = zero_count_reg + CNT_W'(1);
                end
            end
            else if (zero_count_reg == '0)
            begin
                res_fire = 1'b1;
            end
            else
            begin
                step_in_suffix = 1'b1;
                step_left      = zero_count_reg;
                step_acc       = '0;
            end
        end
        else
        begin
            step_left = suffix_left_reg - CNT_W'(1);
            if (suffix_left_reg == CNT_W'(1))
            begin
                res_fire       = 1'b1;
                res_uval       = code_sum[VAL_W] ? {VAL_W{1'b1}} : code_sum[VAL_W-1:0];
                step_zc        = '0;
                step_in_suffix = 1'b0;
                step_left      = '0;
                step_acc       = '0;
            end
        end
    end

    // a second result may only be taken while the output register can take the first
    assign can_go = !(res_fire && pend_valid_reg) || out_free;

    // sequencer and result hand-over
    always_comb
    begin
        state_next       = state_reg;
        bit_cnt_next     = bit_cnt_reg;
        byte_next        = byte_reg;
        last_next        = last_reg;
        zero_count_next  = zero_count_reg;
        in_suffix_next   = in_suffix_reg;
        suffix_left_next = suffix_left_reg;
        suffix_acc_next  = suffix_acc_reg;
        pend_valid_next  = pend_valid_reg;
        pend_uval_next   = pend_uval_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_uval_next    = out_uval_reg;
        out_sval_next    = out_sval_reg;
        out_status_next  = out_status_reg;
        out_last_next    = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    byte_next    = data_byte;
                    last_next    = last_byte;
                    bit_cnt_next = '0;
                    state_next   = S_BITS;
                end
            end
            S_BITS, S_END:
            begin
                if (can_go)
                begin
                    zero_count_next  = step_zc;
                    in_suffix_next   = step_in_suffix;
                    suffix_left_next = step_left;
                    suffix_acc_next  = step_acc;
                    if (res_fire)
                    begin
                        // earlier result is not the last of the run
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_uval_next   = pend_uval_reg;
                            out_sval_next   = se_map(pend_uval_reg);
                            out_status_next = pend_status_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_uval_next   = res_uval;
                        pend_status_next = res_status;
                    end
                    if (state_reg == S_END)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        byte_next    = {byte_reg[6:0], 1'b0};
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                        if (bit_cnt_reg == 3'd7)
                        begin
                            state_next = S_END;
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_uval_next   = pend_uval_reg;
                    out_sval_next   = se_map(pend_uval_reg);
                    out_status_next = pend_status_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bit_cnt_reg     <= '0;
            zero_count_reg  <= '0;
            in_suffix_reg   <= 1'b0;
            suffix_left_reg <= '0;
            suffix_acc_reg  <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bit_cnt_reg     <= bit_cnt_next;
            zero_count_reg  <= zero_count_next;
            in_suffix_reg   <= in_suffix_next;
            suffix_left_reg <= suffix_left_next;
            suffix_acc_reg  <= suffix_acc_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg        <= byte_next;
        last_reg        <= last_next;
        pend_uval_reg   <= pend_uval_next;
        pend_status_reg <= pend_status_next;
        out_uval_reg    <= out_uval_next;
        out_sval_reg    <= out_sval_next;
        out_status_reg  <= out_status_next;
        out_last_reg    <= out_last_next;
    end

    // ports
    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign unsigned_value = out_uval_reg;
    assign signed_value   = $signed(out_sval_reg);
    assign status         = out_status_reg;
    assign last_of_run    = out_last_reg;

endmodule
